>>> design/fvk_pkg.sv
`default_nettype none
package fvk_pkg;

    localparam int SQRT_STEPS = 24;
    localparam int DIV_STEPS  = 32;

    localparam logic [23:0] SPEED_MAX  = 24'hFFFFFF;
    localparam logic [31:0] FACTOR_MAX = 32'hFFFFFFFF;

    // side data carried alongside the square root lanes
    typedef struct packed {
        logic [22:0] eu;
        logic        e_inv;
        logic        m_neg;
    } t_sq_side;

    // side data carried alongside the divider lanes
    typedef struct packed {
        logic [22:0] mass;
        logic [23:0] pmag;
        logic        e_inv;
        logic        m_neg;
        logic        s_sat;
        logic        f_sat;
    } t_dv_side;

endpackage
`default_nettype wire

>>> design/fvk_sqrt_pipe.sv
`default_nettype none
// Floor square root of a 48-bit value, one result bit per register stage.
module fvk_sqrt_pipe (
    input  wire logic        i_clk,
    input  wire logic [47:0] i_radicand,
    output logic      [23:0] o_root
);

    logic [47:0] r_rem  [fvk_pkg::SQRT_STEPS];
    logic [23:0] r_root [fvk_pkg::SQRT_STEPS];

    for (genvar s = 0; s < fvk_pkg::SQRT_STEPS; s++) begin : g_stage
        localparam int K = fvk_pkg::SQRT_STEPS - 1 - s;
        logic [47:0] rem_in;
        logic [23:0] root_in;
        logic [48:0] trial;
        logic [48:0] n_rem;
        logic [23:0] n_root;

        if (s == 0) begin : g_first
            assign rem_in  = i_radicand;
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[s-1];
            assign root_in = r_root[s-1];
        end

        always_comb begin
            // test rem >= (2*root + 2^K) * 2^K
            trial  = ({25'd0, root_in} << (K + 1)) | (49'd1 << (2 * K));
            n_rem  = {1'b0, rem_in};
            n_root = root_in;
            if ({1'b0, rem_in} >= trial) begin
                n_rem  = {1'b0, rem_in} - trial;
                n_root = root_in | (24'd1 << K);
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[s]  <= n_rem[47:0];
            r_root[s] <= n_root;
        end
    end

    assign o_root = r_root[fvk_pkg::SQRT_STEPS-1];

endmodule
`default_nettype wire

>>> design/fvk_div_pipe.sv
`default_nettype none
// Restoring division, one quotient bit per register stage. The caller
// guarantees the start remainder is below the divisor when the result is used.
module fvk_div_pipe (
    input  wire logic [23:0] i_rem0,
    input  wire logic [31:0] i_num,
    input  wire logic [23:0] i_den,
    input  wire logic        i_clk,
    output logic      [31:0] o_quo
);

    logic [23:0] r_rem [fvk_pkg::DIV_STEPS];
    logic [31:0] r_num [fvk_pkg::DIV_STEPS];
    logic [23:0] r_den [fvk_pkg::DIV_STEPS];
    logic [31:0] r_quo [fvk_pkg::DIV_STEPS];

    for (genvar s = 0; s < fvk_pkg::DIV_STEPS; s++) begin : g_stage
        logic [23:0] rem_in;
        logic [31:0] num_in;
        logic [23:0] den_in;
        logic [31:0] quo_in;
        logic [24:0] shifted;
        logic [24:0] n_rem;
        logic        qbit;

        if (s == 0) begin : g_first
            assign rem_in = i_rem0;
            assign num_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign num_in = r_num[s-1];
            assign den_in = r_den[s-1];
            assign quo_in = r_quo[s-1];
        end

        always_comb begin
            shifted = {rem_in, num_in[31]};
            qbit    = (shifted >= {1'b0, den_in});
            n_rem   = qbit ? (shifted - {1'b0, den_in}) : shifted;
        end

        always_ff @(posedge i_clk) begin
            r_rem[s] <= n_rem[23:0];
            r_num[s] <= {num_in[30:0], 1'b0};
            r_den[s] <= den_in;
            r_quo[s] <= {quo_in[30:0], qbit};
        end
    end

    assign o_quo = r_quo[fvk_pkg::DIV_STEPS-1];

endmodule
`default_nettype wire

>>> design/four_vector_kinematics_core.sv
`default_nettype none
// Channel  | Direction | Handshake             | Payload
// request  | in        | start, busy           | i_energy, i_mom_x, i_mom_y, i_mom_z
// result   | out       | o_result_valid strobe | o_rest_mass, o_momentum_size,
//          |           |                       | o_speed_ratio, o_lorentz_factor, flags
//
// One request enters per clock; busy is always low. Each result leaves after its
// request has passed 3 stages clamp/square/sum, 24 square root stages (one root
// bit each), 1 saturation check stage, 32 divider stages (one quotient bit
// each). Synchronous active-low reset clears only the valid chain.
// The receiver cannot stall, so the pipeline never halts.
module four_vector_kinematics_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic signed [23:0] i_energy,
    input  wire logic signed [23:0] i_mom_x,
    input  wire logic signed [23:0] i_mom_y,
    input  wire logic signed [23:0] i_mom_z,
    output logic             o_result_valid,
    output logic      [22:0] o_rest_mass,
    output logic      [23:0] o_momentum_size,
    output logic      [23:0] o_speed_ratio,
    output logic      [31:0] o_lorentz_factor,
    output logic             o_energy_invalid,
    output logic             o_mass_negative,
    output logic             o_speed_saturated,
    output logic             o_factor_saturated
);

    localparam int SQ_N = fvk_pkg::SQRT_STEPS;
    localparam int DV_N = fvk_pkg::DIV_STEPS;

    assign busy = 1'b0;

    // stage 1: clamp negative energy to zero
    logic               r1_v;
    logic        [22:0] r1_eu;
    logic               r1_inv;
    logic signed [23:0] r1_px, r1_py, r1_pz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= start;
        end
        r1_inv <= i_energy[23];
        r1_eu  <= i_energy[23] ? 23'd0 : i_energy[22:0];
        r1_px  <= i_mom_x;
        r1_py  <= i_mom_y;
        r1_pz  <= i_mom_z;
    end

    // stage 2: squares, one multiplier each
    logic        r2_v;
    logic [45:0] r2_esq;
    logic [46:0] r2_xs, r2_ys, r2_zs;
    logic [22:0] r2_eu;
    logic        r2_inv;
    logic signed [47:0] sq_x, sq_y, sq_z;

    always_comb begin
        sq_x = r1_px * r1_px;
        sq_y = r1_py * r1_py;
        sq_z = r1_pz * r1_pz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
        r2_esq <= r1_eu * r1_eu;
        r2_xs  <= sq_x[46:0];
        r2_ys  <= sq_y[46:0];
        r2_zs  <= sq_z[46:0];
        r2_eu  <= r1_eu;
        r2_inv <= r1_inv;
    end

    // stage 3: momentum square sum and Minkowski square
    logic        r3_v;
    logic [47:0] r3_psq;
    logic [45:0] r3_m2;
    logic        r3_neg;
    logic [22:0] r3_eu;
    logic        r3_inv;
    logic [47:0] psq;

    assign psq = {1'b0, r2_xs} + {1'b0, r2_ys} + {1'b0, r2_zs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
        r3_psq <= psq;
        r3_neg <= ({2'b0, r2_esq} < psq);
        r3_m2  <= ({2'b0, r2_esq} < psq) ? 46'd0 : (r2_esq - psq[45:0]);
        r3_eu  <= r2_eu;
        r3_inv <= r2_inv;
    end

    // square root lanes
    logic [23:0] pmag_root, mass_root;

    fvk_sqrt_pipe u_sqrt_p (
        .i_clk      (i_clk),
        .i_radicand (r3_psq),
        .o_root     (pmag_root)
    );

    fvk_sqrt_pipe u_sqrt_m (
        .i_clk      (i_clk),
        .i_radicand ({2'b0, r3_m2}),
        .o_root     (mass_root)
    );

    logic              r_sq_v    [SQ_N];
    fvk_pkg::t_sq_side r_sq_side [SQ_N];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < SQ_N; i++) begin
            if (!i_rst_n) begin
                r_sq_v[i] <= 1'b0;
            end else begin
                r_sq_v[i] <= (i == 0) ? r3_v : r_sq_v[i-1];
            end
            if (i == 0) begin
                r_sq_side[i] <= '{eu: r3_eu, e_inv: r3_inv, m_neg: r3_neg};
            end else begin
                r_sq_side[i] <= r_sq_side[i-1];
            end
        end
    end

    // stage 4: detect saturation, set up the two divisions
    fvk_pkg::t_sq_side sq_last;
    logic [22:0]       mass_w;
    logic              s_sat, f_sat;
    logic              r4_v;
    fvk_pkg::t_dv_side r4_side;
    logic [23:0]       r4_b_rem0, r4_b_den, r4_g_rem0, r4_g_den;
    logic [31:0]       r4_b_num, r4_g_num;

    always_comb begin
        sq_last = r_sq_side[SQ_N-1];
        mass_w  = mass_root[22:0];
        // beta exceeds its range when |p| >= 4 E
        s_sat   = (sq_last.eu == 23'd0) ||
                  ({1'b0, pmag_root} >= {sq_last.eu, 2'b00});
        // gamma exceeds its range when E >> 16 >= mass
        f_sat   = (mass_w == 23'd0) ||
                  ({16'd0, sq_last.eu[22:16]} >= mass_w);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else begin
            r4_v <= r_sq_v[SQ_N-1];
        end
        r4_side   <= '{mass: mass_w, pmag: pmag_root, e_inv: sq_last.e_inv,
                       m_neg: sq_last.m_neg, s_sat: s_sat, f_sat: f_sat};
        r4_b_rem0 <= {10'd0, pmag_root[23:10]};
        r4_b_num  <= {pmag_root[9:0], 22'd0};
        r4_b_den  <= {1'b0, sq_last.eu};
        r4_g_rem0 <= {17'd0, sq_last.eu[22:16]};
        r4_g_num  <= {sq_last.eu[15:0], 16'd0};
        r4_g_den  <= {1'b0, mass_w};
    end

    // divider lanes
    logic [31:0] beta_q, gamma_q;

    fvk_div_pipe u_div_b (
        .i_rem0 (r4_b_rem0),
        .i_num  (r4_b_num),
        .i_den  (r4_b_den),
        .i_clk  (i_clk),
        .o_quo  (beta_q)
    );

    fvk_div_pipe u_div_g (
        .i_rem0 (r4_g_rem0),
        .i_num  (r4_g_num),
        .i_den  (r4_g_den),
        .i_clk  (i_clk),
        .o_quo  (gamma_q)
    );

    logic              r_dv_v    [DV_N];
    fvk_pkg::t_dv_side r_dv_side [DV_N];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DV_N; i++) begin
            if (!i_rst_n) begin
                r_dv_v[i] <= 1'b0;
            end else begin
                r_dv_v[i] <= (i == 0) ? r4_v : r_dv_v[i-1];
            end
            r_dv_side[i] <= (i == 0) ? r4_side : r_dv_side[i-1];
        end
    end

    // result: apply saturation to the quotients
    fvk_pkg::t_dv_side dv_last;

    assign dv_last            = r_dv_side[DV_N-1];
    assign o_result_valid     = r_dv_v[DV_N-1];
    assign o_rest_mass        = dv_last.mass;
    assign o_momentum_size    = dv_last.pmag;
    assign o_speed_ratio      = dv_last.s_sat ? fvk_pkg::SPEED_MAX : beta_q[23:0];
    assign o_lorentz_factor   = dv_last.f_sat ? fvk_pkg::FACTOR_MAX : gamma_q;
    assign o_energy_invalid   = dv_last.e_inv;
    assign o_mass_negative    = dv_last.m_neg;
    assign o_speed_saturated  = dv_last.s_sat;
    assign o_factor_saturated = dv_last.f_sat;

`ifndef NO_ASSERTIONS
    a_neg_mass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_mass_negative) |->
            (o_rest_mass == 23'd0 && o_factor_saturated))
        else $error("negative mass square without zero mass and gamma saturation");

    a_gamma_mass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_factor_saturated) |-> (o_rest_mass != 23'd0))
        else $error("gamma computed from a zero mass");

    a_bad_energy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_energy_invalid) |-> o_speed_saturated)
        else $error("rejected energy did not saturate beta");
`endif

endmodule
`default_nettype wire
